FILE: hw/rtl/mbse_pkg.sv
// Shared types, constants and helper functions for the multiboot stream encryptor.
// Every RTL file uses this package through scoped names; it depends on nothing.
package mbse_pkg;

   // Transfer limits
   localparam int MAX_PROGRAM_BYTES = 262144;
   localparam int OFFSET_W          = $clog2(MAX_PROGRAM_BYTES + 1);
   localparam int LENGTH_W          = 18;
   localparam int QUEUE_DEPTH       = 2;
   localparam int QUEUE_PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Cipher constants
   localparam logic [31:0] KEY_UNWRAP     = 32'h6f646573;
   localparam logic [31:0] KEY_MULT       = 32'h6177614b;
   localparam logic [31:0] MASK_CONST     = 32'h20796220;
   localparam logic [31:0] OFFSET_BIAS    = 32'h02000000;
   localparam logic [31:0] AUTH_MASK      = 32'h3f80ffff;
   localparam logic [31:0] AUTH_FILL      = 32'h80808080;
   localparam logic [15:0] CRC_POLY       = 16'ha1c1;
   localparam logic [15:0] CRC_INIT       = 16'h15a0;
   localparam logic [15:0] SPEED_ZERO_TAG = 16'h0070;
   localparam int          HEADER_BYTES   = 'h200;
   localparam int          CRYPT_START    = 'hc0;
   localparam int          CHANNEL_OFFSET = 'hc4;

   typedef logic [OFFSET_W-1:0] offset_type;

   // Request command codes
   typedef enum logic [0:0] {
      CMD_START = 1'b0,
      CMD_EMIT  = 1'b1
   } cmd_type;

   // Kind of word on the response channel
   typedef enum logic [1:0] {
      KIND_AUTH  = 2'd0,
      KIND_PROG  = 2'd1,
      KIND_FINAL = 2'd2
   } kind_type;

   // Configuration register indexes
   typedef enum logic [2:0] {
      REG_CHALLENGE = 3'd0,
      REG_COLOR     = 3'd1,
      REG_SPEED     = 3'd2,
      REG_LENGTH    = 3'd3,
      REG_CHANNEL   = 3'd4
   } csr_index_type;

   // Configuration register file contents
   typedef struct packed {
      logic [31:0]         challenge;
      logic [2:0]          color;
      logic signed [3:0]   speed;
      logic [LENGTH_W-1:0] length;
      logic [1:0]          channel;
   } cfg_type;

   // One classified request between front and back
   typedef struct packed {
      logic        is_start;
      logic [31:0] data;
      offset_type  total;
   } queue_entry_type;

   // Transfer size: length rounded up to 8, clamped to [header, max]
   function automatic offset_type total_bytes(logic [LENGTH_W-1:0] len);
      logic [LENGTH_W:0] rnd;
      rnd = ({1'b0, len} + (LENGTH_W + 1)'(7)) & ~(LENGTH_W + 1)'(7);
      if (rnd < (LENGTH_W + 1)'(HEADER_BYTES)) begin
         rnd = (LENGTH_W + 1)'(HEADER_BYTES);
      end
      if (rnd > (LENGTH_W + 1)'(MAX_PROGRAM_BYTES)) begin
         rnd = (LENGTH_W + 1)'(MAX_PROGRAM_BYTES);
      end
      return OFFSET_W'(rnd);
   endfunction

   // Number of eight-byte pairs past the header
   function automatic logic [15:0] pair_count(offset_type tot);
      return 16'((tot - OFFSET_W'(HEADER_BYTES)) >> 3);
   endfunction

   // Pack palette and length into the authentication word
   function automatic logic [31:0] auth_word(logic [15:0] pairs, logic [2:0] color,
                                             logic [3:0] speed);
      logic [4:0]  ext;
      logic [4:0]  mag;
      logic [15:0] coded;
      logic [31:0] p32;
      logic [31:0] t1;
      logic [31:0] b;
      logic [31:0] t2;
      logic [31:0] t3;
      ext = {speed[3], speed};
      mag = 5'(~ext + 5'd1);
      if (speed[3]) begin
         coded = ((16'(mag) + 16'd2) << 1) | {9'b0, color, 4'b0};
      end else if (speed == 4'd0) begin
         coded = {12'b0, color, 1'b0} | SPEED_ZERO_TAG;
      end else begin
         coded = ((16'(speed[2:0]) - 16'd1) << 1) | {9'b0, color, 4'b0};
      end
      coded[0] = coded[0] | pairs[14];
      p32 = {16'b0, pairs};
      t1  = (((p32 << 16) | 32'h00003f80) & AUTH_MASK) << 1;
      b   = {{24{t1[15]}}, t1[15:8]};
      t1  = t1 + ((b & p32) << 16);
      t2  = {8'b0, coded[7:0], 16'b0} + (t1 & 32'h00ff0000) + ((t1 >> 8) & 32'h00ffff00);
      t3  = {coded, 16'b0} | ((t2 << 8) & 32'hff000000) | (t1 >> 16) | AUTH_FILL;
      return t3 ^ (t3[9] ? KEY_UNWRAP : KEY_MULT);
   endfunction

   // CRC-16 over one word, LSB first; linear, so it flattens to an XOR network
   function automatic logic [15:0] crc_word(logic [15:0] crc_in, logic [31:0] w);
      logic [15:0] c;
      c = crc_in;
      for (int i = 0; i < 32; i++) begin
         if (w[i] ^ c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

FILE: hw/rtl/mbse_if.sv
// Handshake channel interfaces for the multiboot stream encryptor.
// Depends on mbse_pkg for the offset width.

// Request channel: command and four program bytes
interface mbse_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [31:0] prog_word;
   modport source (output valid, output cmd, output prog_word, input ready);
   modport sink   (input valid, input cmd, input prog_word, output ready);
endinterface

// Response channel: one transfer word per request
interface mbse_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [31:0]                  out_word;
   logic [1:0]                   word_kind;
   logic [mbse_pkg::OFFSET_W-1:0] byte_offset;
   logic                         is_last;
   logic                         status;
   modport source (output valid, output out_word, output word_kind, output byte_offset,
                   output is_last, output status, input ready);
   modport sink   (input valid, input out_word, input word_kind, input byte_offset,
                   input is_last, input status, output ready);
endinterface

// Configuration write channel
interface mbse_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  addr;
   logic [31:0] wdata;
   modport source (output valid, output addr, output wdata, input ready);
   modport sink   (input valid, input addr, input wdata, output ready);
endinterface

FILE: hw/rtl/mbse_front.sv
// Front end: accepts requests, classifies them and builds the authentication word.
// Depends on mbse_pkg and mbse_req_if; feeds mbse_queue.
module mbse_front (
   mbse_req_if.sink                 req_ch,
   input  mbse_pkg::cfg_type        cfg,
   input  logic                     queue_full,
   output logic                     push,
   output mbse_pkg::queue_entry_type push_entry
);

   mbse_pkg::offset_type tot;
   logic                 is_start;

   // Take a request whenever the queue has room
   assign req_ch.ready = !queue_full;
   assign push         = req_ch.valid && !queue_full;

   // Classify the request; start requests carry the packed authentication word
   always_comb begin
      tot      = mbse_pkg::total_bytes(cfg.length);
      is_start = (req_ch.cmd == mbse_pkg::CMD_START);
      push_entry.is_start = is_start;
      push_entry.total    = tot;
      if (is_start) begin
         push_entry.data = mbse_pkg::auth_word(mbse_pkg::pair_count(tot), cfg.color,
                                               cfg.speed);
      end else begin
         push_entry.data = req_ch.prog_word;
      end
   end

endmodule

FILE: hw/rtl/mbse_queue.sv
// Two-entry request queue between front and back end.
// Depends on mbse_pkg for the entry type and depth.
module mbse_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  mbse_pkg::queue_entry_type push_entry,
   output logic                      full,
   input  logic                      pop,
   output logic                      not_empty,
   output mbse_pkg::queue_entry_type head
);

   mbse_pkg::queue_entry_type            slot_ff [mbse_pkg::QUEUE_DEPTH];
   logic [mbse_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [mbse_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [mbse_pkg::QUEUE_CNT_W-1:0]     count_ff, count_in;

   assign full      = (count_ff == mbse_pkg::QUEUE_CNT_W'(mbse_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + mbse_pkg::QUEUE_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + mbse_pkg::QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + mbse_pkg::QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - mbse_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold entries
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: hw/rtl/mbse_back.sv
// Back end: session state, CRC, key stepping and the response register.
// Depends on mbse_pkg and mbse_rsp_if; drains mbse_queue.
module mbse_back (
   input  logic                      clock,
   input  logic                      reset,
   input  mbse_pkg::cfg_type         cfg,
   input  logic                      head_valid,
   input  mbse_pkg::queue_entry_type head,
   output logic                      pop,
   mbse_rsp_if.source                rsp_ch
);

   // Session state
   logic [31:0]          key_ff, key_in;
   logic [15:0]          crc_ff, crc_in;
   mbse_pkg::offset_type offset_ff, offset_in;
   mbse_pkg::offset_type total_ff, total_in;
   logic                 active_ff, active_in;

   // Response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          word_ff, word_in;
   mbse_pkg::kind_type   kind_ff, kind_in;
   mbse_pkg::offset_type rsp_off_ff, rsp_off_in;
   logic                 last_ff, last_in;
   logic                 status_ff, status_in;

   logic                 final_hit;
   logic                 crypt;
   logic [31:0]          plain;
   logic [31:0]          key_step;
   logic [31:0]          off_term;

   // Drain the queue whenever the response register is free or being taken
   assign pop = head_valid && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      key_in       = key_ff;
      crc_in       = crc_ff;
      offset_in    = offset_ff;
      total_in     = total_ff;
      active_in    = active_ff;
      rsp_valid_in = rsp_valid_ff;
      word_in      = word_ff;
      kind_in      = kind_ff;
      rsp_off_in   = rsp_off_ff;
      last_in      = last_ff;
      status_in    = status_ff;

      final_hit = (offset_ff == total_ff);
      crypt     = (offset_ff >= mbse_pkg::OFFSET_W'(mbse_pkg::CRYPT_START));
      key_step  = 32'(key_ff * mbse_pkg::KEY_MULT) + 32'd1;
      off_term  = ~(mbse_pkg::OFFSET_BIAS + 32'(offset_ff)) + 32'd1;

      // Plain word: program data, channel number or checksum trailer
      if (final_hit) begin
         plain = {16'(offset_ff), crc_ff};
      end else if (offset_ff == mbse_pkg::OFFSET_W'(mbse_pkg::CHANNEL_OFFSET)) begin
         plain = {22'b0, cfg.channel, 8'b0};
      end else begin
         plain = head.data;
      end

      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (pop) begin
         rsp_valid_in = 1'b1;
         if (head.is_start) begin
            // Restart the session and emit the authentication word
            key_in     = cfg.challenge ^ mbse_pkg::KEY_UNWRAP;
            crc_in     = mbse_pkg::CRC_INIT;
            offset_in  = '0;
            total_in   = head.total;
            active_in  = 1'b1;
            word_in    = head.data;
            kind_in    = mbse_pkg::KIND_AUTH;
            rsp_off_in = '0;
            last_in    = 1'b0;
            status_in  = 1'b0;
         end else if (!active_ff) begin
            // No session: flag the response and leave state alone
            word_in    = '0;
            kind_in    = mbse_pkg::KIND_AUTH;
            rsp_off_in = '0;
            last_in    = 1'b0;
            status_in  = 1'b1;
         end else begin
            if (!final_hit && crypt) begin
               crc_in = mbse_pkg::crc_word(crc_ff, plain);
            end
            if (crypt) begin
               key_in  = key_step;
               word_in = plain ^ key_step ^ off_term ^ mbse_pkg::MASK_CONST;
            end else begin
               word_in = plain;
            end
            kind_in    = final_hit ? mbse_pkg::KIND_FINAL : mbse_pkg::KIND_PROG;
            rsp_off_in = offset_ff;
            last_in    = final_hit;
            status_in  = 1'b0;
            if (final_hit || offset_ff >= total_ff) begin
               active_in = 1'b0;
            end else begin
               offset_in = offset_ff + mbse_pkg::OFFSET_W'(4);
            end
         end
      end
   end

   // Session and handshake state
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= '0;
         crc_ff       <= mbse_pkg::CRC_INIT;
         offset_ff    <= '0;
         total_ff     <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_ff       <= key_in;
         crc_ff       <= crc_in;
         offset_ff    <= offset_in;
         total_ff     <= total_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      word_ff    <= word_in;
      kind_ff    <= kind_in;
      rsp_off_ff <= rsp_off_in;
      last_ff    <= last_in;
      status_ff  <= status_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_word    = word_ff;
   assign rsp_ch.word_kind   = kind_ff;
   assign rsp_ch.byte_offset = rsp_off_ff;
   assign rsp_ch.is_last     = last_ff;
   assign rsp_ch.status      = status_ff;

`ifndef SYNTH
   // A no-session response carries nothing else
   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff |-> word_ff == '0 && rsp_off_ff == '0 && !last_ff)
      else $error("no-session response carries data");

   // The last flag marks exactly the checksum word
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> last_ff == (kind_ff == mbse_pkg::KIND_FINAL))
      else $error("last flag and word kind disagree");

   // The session closes once the checksum word is issued
   a_close: assert property (@(posedge clock) disable iff (reset)
      pop && !head.is_start && active_ff && final_hit |=> !active_ff)
      else $error("session still open after checksum word");

   // Offsets stay word aligned and within the transfer
   a_offset: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> offset_ff[1:0] == 2'b00 && offset_ff <= total_ff)
      else $error("session offset out of range");
`endif

endmodule

FILE: hw/rtl/multiboot_stream_encryptor_unit.sv
// Top level of the multiboot stream encryptor: configuration registers and
// the front end, request queue and back end. Depends on mbse_pkg and the mbse interfaces.
//
// Usage:
//   csr_ch  writes one configuration register per handshake (always ready);
//           write only while no request is outstanding.
//   req_ch  cmd 0 starts a session and yields the authentication word;
//           cmd 1 yields the next transfer word from prog_word.
//   rsp_ch  exactly one response per request, in request order.
// Throughput: one request per cycle while rsp_ch.ready is high; the session key multiply
//   and the CRC update of one word are both combinational in the back end.
// Path: an accepted request passes through a queue entry, then the response
//   register, before it shows on rsp_ch.
// Stall: when rsp_ch.ready is low the response register holds, the
//   two-entry queue fills, and req_ch.ready drops once it is full.
// Reset: synchronous; clears the queue, ends any session, and returns the
//   registers to their defaults (program length 512, others zero).
module multiboot_stream_encryptor_unit (
   input  logic       clock,
   input  logic       reset,
   mbse_csr_if.sink   csr_ch,
   mbse_req_if.sink   req_ch,
   mbse_rsp_if.source rsp_ch
);

   mbse_pkg::cfg_type         cfg_ff;
   mbse_pkg::cfg_type         cfg_in;
   logic                      push;
   mbse_pkg::queue_entry_type push_entry;
   logic                      queue_full;
   logic                      pop;
   logic                      head_valid;
   mbse_pkg::queue_entry_type head;

   assign csr_ch.ready = 1'b1;

   // Decode configuration writes; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (mbse_pkg::csr_index_type'(csr_ch.addr))
            mbse_pkg::REG_CHALLENGE: cfg_in.challenge = csr_ch.wdata;
            mbse_pkg::REG_COLOR:     cfg_in.color     = csr_ch.wdata[2:0];
            mbse_pkg::REG_SPEED:     cfg_in.speed     = csr_ch.wdata[3:0];
            mbse_pkg::REG_LENGTH:    cfg_in.length    = csr_ch.wdata[mbse_pkg::LENGTH_W-1:0];
            mbse_pkg::REG_CHANNEL:   cfg_in.channel   = csr_ch.wdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.challenge <= '0;
         cfg_ff.color     <= '0;
         cfg_ff.speed     <= '0;
         cfg_ff.length    <= mbse_pkg::LENGTH_W'(mbse_pkg::HEADER_BYTES);
         cfg_ff.channel   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mbse_front u_front (
      .req_ch     (req_ch),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   mbse_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (head_valid),
      .head       (head)
   );

   mbse_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule
